### src/obs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obs_pkg: shared types, constants and bit-search helpers
// Two-level 64-ary bitmap set with successor and predecessor search.
// ----------------------------------------------------------------------------
package obs_pkg;

    localparam int WORD_W     = 64;
    localparam int BIT_IDX_W  = 6;
    localparam int LEAF_DEPTH = 64;
    localparam int KEY_W      = 14;
    localparam int UNIV_W     = 13;
    localparam int SLOT_W     = 12;
    localparam int ACTION_W   = 3;

    localparam logic [UNIV_W-1:0] CAPACITY = 13'd4096;
    localparam logic [KEY_W-1:0]  POS_NONE = 14'h3FFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_ERASE  = 3'd1,
        ACT_SUCC   = 3'd2,
        ACT_PRED   = 3'd3,
        ACT_MEMBER = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL1,
        S_EVAL2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic eval1;
        logic eval2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic no_result;
        logic second;
    } t_stat;

    // index of the lowest set bit, zero for an empty word
    function automatic logic [BIT_IDX_W-1:0] find_first(input logic [WORD_W-1:0] w);
        logic [BIT_IDX_W-1:0] n;
        n = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (w[k]) begin
                n = BIT_IDX_W'(k);
            end
        end
        return n;
    endfunction

    // index of the highest set bit, zero for an empty word
    function automatic logic [BIT_IDX_W-1:0] find_last(input logic [WORD_W-1:0] w);
        logic [BIT_IDX_W-1:0] n;
        n = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (w[k]) begin
                n = BIT_IDX_W'(k);
            end
        end
        return n;
    endfunction

    // a found successor at or above the universe reports the universe
    function automatic logic [KEY_W-1:0] clamp_succ(input logic [SLOT_W-1:0] p,
                                                    input logic [UNIV_W-1:0] u);
        logic [UNIV_W-1:0] p13;
        p13 = {1'b0, p};
        return (p13 >= u) ? {1'b0, u} : {2'b00, p};
    endfunction

endpackage

### src/ordered_bitset_successor_top.sv
`timescale 1ns / 1ps
// Sequence: insert and erase go through accept and the first evaluation and give no result.
// Membership tests and clamped searches go through accept, the first evaluation and the
// done state; searches that go through the summary word add a second leaf read.
// The block takes no new transaction until the last one is through, and a result held
// downstream stalls it in the done state. Synchronous active-low reset empties the set
// at once through per-word valid bits and sets universe_size to 4096.
// ----------------------------------------------------------------------------
// ordered_bitset_successor_top: two-level 64-ary bitmap set
// Insert, erase, successor, predecessor and membership over 4096 keys.
// ----------------------------------------------------------------------------
module ordered_bitset_successor_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [obs_pkg::UNIV_W-1:0]   i_cfg_wdata,  // universe_size
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [15:0]                  i_s_tdata,    // [13:0] key, [15:14] zero
    input  logic [obs_pkg::ACTION_W-1:0] i_s_tuser,    // [2:0] action
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [15:0]                  o_m_tdata     // [13:0] position, [14] is_member
);
    import obs_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [KEY_W-1:0]  position;
    logic              is_member;

    obs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    obs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_action    (i_s_tuser),
        .i_key       (i_s_tdata[KEY_W-1:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_position  (position),
        .o_is_member (is_member)
    );

    assign o_m_tdata = {1'b0, is_member, position};

`ifndef SYNTHESIS
    // a new result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("result loaded over a pending output");

    // an accepted transaction is evaluated in the very next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> cmd.eval1)
        else $error("accepted transaction not evaluated");

    // the second leaf read only follows a first evaluation that asked for it
    a_eval2_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.eval2 |-> ($past(cmd.eval1) && $past(stat.second)))
        else $error("second evaluation without request");

    // nothing is accepted while a transaction is in flight
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.eval1 || cmd.eval2) |-> !o_s_tready)
        else $error("input ready during evaluation");
`endif

endmodule

### src/obs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obs_ctrl: sequencing state machine
// Steps one transaction through accept, leaf word evaluation, an optional
// second leaf read and, for transactions with a result, the hand-off into the output register.
// ----------------------------------------------------------------------------
module obs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output obs_pkg::t_cmd o_cmd,
    input  obs_pkg::t_stat i_stat
);
    import obs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EVAL1;
                end
            end
            S_EVAL1: begin
                if (i_stat.no_result) begin
                    n_state = S_IDLE;
                end else if (i_stat.second) begin
                    n_state = S_EVAL2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EVAL2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_EVAL1: begin
                o_cmd.eval1 = 1'b1;
            end
            S_EVAL2: begin
                o_cmd.eval2 = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // hold the result until the downstream side takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

### src/obs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obs_dpath: bitmap storage and search datapath
// Leaf word memory with per-word valid bits, summary word, universe register,
// find-first and find-last logic, and the result and output registers.
// ----------------------------------------------------------------------------
module obs_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [obs_pkg::UNIV_W-1:0]    i_cfg_wdata,
    input  logic [obs_pkg::ACTION_W-1:0]  i_action,
    input  logic [obs_pkg::KEY_W-1:0]     i_key,
    input  obs_pkg::t_cmd                 i_cmd,
    output obs_pkg::t_stat                o_stat,
    output logic [obs_pkg::KEY_W-1:0]     o_position,
    output logic                          o_is_member
);
    import obs_pkg::*;

    logic [WORD_W-1:0]     mem [LEAF_DEPTH];
    logic [LEAF_DEPTH-1:0] r_valid;
    logic [WORD_W-1:0]     r_summary;
    logic [UNIV_W-1:0]     r_univ;

    logic [WORD_W-1:0]     r_rd_data;
    logic                  r_rd_ok;

    t_action               r_act;
    logic [SLOT_W-1:0]     r_x;
    logic                  r_inr;
    logic                  r_imm;
    logic [KEY_W-1:0]      r_imm_pos;
    logic [BIT_IDX_W-1:0]  r_j;

    logic [KEY_W-1:0]      r_res_pos;
    logic                  r_res_mem;
    logic [KEY_W-1:0]      r_out_pos;
    logic                  r_out_mem;

    // accept-time decode
    logic                  key_neg, key_ge_u;
    logic [UNIV_W-1:0]     u_m1;
    logic [SLOT_W-1:0]     n_x;
    logic                  n_imm;
    logic [KEY_W-1:0]      n_imm_pos;

    // first evaluation
    logic [WORD_W-1:0]     w, bit_r, m_s, m_p, s_s, s_p, wr_data;
    logic [BIT_IDX_W-1:0]  slot_i, slot_r, j_sel;
    logic                  second, wr_en;
    logic [KEY_W-1:0]      e1_pos;
    logic                  e1_mem;

    // second evaluation
    logic [WORD_W-1:0]     w2;
    logic [KEY_W-1:0]      e2_pos;

    logic                  rd_en;
    logic [BIT_IDX_W-1:0]  rd_addr;

    always_comb begin
        key_neg   = i_key[KEY_W-1];
        key_ge_u  = !key_neg && (i_key[UNIV_W-1:0] >= r_univ);
        u_m1      = r_univ - UNIV_W'(1);
        n_x       = i_key[SLOT_W-1:0];
        n_imm     = 1'b0;
        n_imm_pos = POS_NONE;
        case (t_action'(i_action))
            ACT_SUCC: begin
                n_x       = key_neg ? '0 : i_key[SLOT_W-1:0];
                n_imm     = key_ge_u;
                n_imm_pos = {1'b0, r_univ};
            end
            ACT_PRED: begin
                n_x       = key_ge_u ? u_m1[SLOT_W-1:0] : i_key[SLOT_W-1:0];
                n_imm     = key_neg || (key_ge_u && (r_univ == '0));
                n_imm_pos = POS_NONE;
            end
            default: begin
                n_imm = 1'b0;
            end
        endcase
    end

    always_comb begin
        slot_i = r_x[SLOT_W-1:BIT_IDX_W];
        slot_r = r_x[BIT_IDX_W-1:0];
        w      = r_rd_ok ? r_rd_data : '0;
        bit_r  = WORD_W'(1) << slot_r;
        m_s    = w & ({WORD_W{1'b1}} << slot_r);
        m_p    = w & ((WORD_W'(2) << slot_r) - WORD_W'(1));
        s_s    = r_summary & ~((WORD_W'(2) << slot_i) - WORD_W'(1));
        s_p    = r_summary & ((WORD_W'(1) << slot_i) - WORD_W'(1));

        second  = 1'b0;
        j_sel   = find_first(s_s);
        e1_pos  = '0;
        e1_mem  = 1'b0;
        wr_en   = 1'b0;
        wr_data = w | bit_r;
        o_stat.no_result = 1'b0;
        case (r_act)
            ACT_INSERT: begin
                o_stat.no_result = 1'b1;
                wr_en   = r_inr;
                wr_data = w | bit_r;
            end
            ACT_ERASE: begin
                o_stat.no_result = 1'b1;
                wr_en   = r_inr;
                wr_data = w & ~bit_r;
            end
            ACT_SUCC: begin
                j_sel = find_first(s_s);
                if (r_imm) begin
                    e1_pos = r_imm_pos;
                end else if (m_s != '0) begin
                    e1_pos = clamp_succ({slot_i, find_first(m_s)}, r_univ);
                end else if (s_s != '0) begin
                    second = 1'b1;
                end else begin
                    e1_pos = {1'b0, r_univ};
                end
            end
            ACT_PRED: begin
                j_sel = find_last(s_p);
                if (r_imm) begin
                    e1_pos = r_imm_pos;
                end else if (m_p != '0) begin
                    e1_pos = {2'b00, slot_i, find_last(m_p)};
                end else if (s_p != '0) begin
                    second = 1'b1;
                end else begin
                    e1_pos = POS_NONE;
                end
            end
            ACT_MEMBER: begin
                e1_pos = '0;
                e1_mem = r_inr && w[slot_r];
            end
            default: begin
                o_stat.no_result = 1'b1;
            end
        endcase
        o_stat.second = second;
    end

    always_comb begin
        w2 = r_rd_ok ? r_rd_data : '0;
        if (r_act == ACT_SUCC) begin
            e2_pos = clamp_succ({r_j, find_first(w2)}, r_univ);
        end else begin
            e2_pos = {2'b00, r_j, find_last(w2)};
        end
    end

    assign rd_en   = i_cmd.accept || (i_cmd.eval1 && second);
    assign rd_addr = i_cmd.accept ? n_x[SLOT_W-1:BIT_IDX_W] : j_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval1 && wr_en) begin
            mem[slot_i] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_summary <= '0;
            r_univ    <= CAPACITY;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_univ <= (i_cfg_wdata > CAPACITY) ? CAPACITY : i_cfg_wdata;
            end
            if (rd_en) begin
                r_rd_ok <= r_valid[rd_addr];
            end
            if (i_cmd.eval1 && wr_en) begin
                r_valid[slot_i] <= 1'b1;
                // summary bit tracks whether the leaf word is nonzero
                r_summary[slot_i] <= (wr_data != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act     <= t_action'(i_action);
            r_x       <= n_x;
            r_inr     <= !key_neg && !key_ge_u;
            r_imm     <= n_imm;
            r_imm_pos <= n_imm_pos;
        end
        if (i_cmd.eval1) begin
            r_j       <= j_sel;
            r_res_pos <= e1_pos;
            r_res_mem <= e1_mem;
        end
        if (i_cmd.eval2) begin
            r_res_pos <= e2_pos;
            r_res_mem <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_pos <= r_res_pos;
            r_out_mem <= r_res_mem;
        end
    end

    assign o_position  = r_out_pos;
    assign o_is_member = r_out_mem;

endmodule
